@@ hw/rtl/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the pixel packet time decoder.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned TrigWrapBitsDefault = 16;
  localparam int unsigned QueueDepthDefault   = 4;

  localparam logic [15:0] MarginReset  = 16'd1000;
  localparam logic [47:0] QuarterEpoch = 48'h0000_1000_0000;
  localparam logic [14:0] TotScale     = 15'd25;

  localparam logic [3:0] HdrPixelA   = 4'hA;
  localparam logic [3:0] HdrPixelB   = 4'hB;
  localparam logic [3:0] HdrGlobalA  = 4'h4;
  localparam logic [3:0] HdrGlobalB  = 4'h6;
  localparam logic [3:0] SubTrigger  = 4'hF;
  localparam logic [3:0] SubTimeLow  = 4'h4;
  localparam logic [3:0] SubTimeHigh = 4'h5;

  localparam logic KindPixel   = 1'b0;
  localparam logic KindTrigger = 1'b1;

  localparam logic [1:0] WarnNone     = 2'd0;
  localparam logic [1:0] WarnEpoch    = 2'd1;
  localparam logic [1:0] WarnWrap     = 2'd2;
  localparam logic [1:0] WarnBackJump = 2'd3;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_TRIGGER,
    OP_TIME_LOW,
    OP_TIME_HIGH
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [63:0]        word;
    logic [7:0]         column;
    logic [7:0]         row_index;
    logic [14:0]        tot_value;
    logic signed [5:0]  adj;
  } qent_t;

endpackage

@@ hw/rtl/ppt_front.sv @@
// ----------------------------------------------------------------------------
// ppt_front
// Packet classifier: decodes the header, slices the pixel fields and drops
// packets that carry nothing.
// ----------------------------------------------------------------------------
module ppt_front import ppt_pkg::*; (
  input  logic        in_valid_i,
  input  logic [63:0] packet_word_i,
  output logic        in_ready_o,
  input  logic        queue_full_i,
  output logic        push_o,
  output qent_t       ent_o
);

  logic [3:0]  hdr;
  logic [3:0]  sub;
  logic        keep;
  logic [9:0]  tot_raw;
  logic [3:0]  ftoa;
  logic [3:0]  phase;
  logic [4:0]  phase_x;

  assign hdr     = packet_word_i[63:60];
  assign sub     = packet_word_i[59:56];
  assign tot_raw = packet_word_i[29:20];
  assign ftoa    = packet_word_i[19:16];

  always_comb begin
    ent_o.op        = OP_PIXEL;
    ent_o.word      = packet_word_i;
    ent_o.column    = {packet_word_i[59:53], packet_word_i[46]};
    ent_o.row_index = {packet_word_i[52:47], packet_word_i[45:44]};
    ent_o.tot_value = 15'({5'b0, tot_raw} * TotScale);
    phase           = ent_o.column[4:1];
    phase_x         = (phase == 4'd0) ? 5'd16 : {1'b0, phase};
    ent_o.adj       = 6'({1'b0, phase_x} - {2'b0, ftoa});
    keep            = 1'b0;
    unique case (hdr) inside
      HdrPixelA, HdrPixelB: begin
        keep = 1'b1;
      end
      HdrGlobalA, HdrGlobalB: begin
        unique case (sub)
          SubTrigger: begin
            ent_o.op = OP_TRIGGER;
            keep     = 1'b1;
          end
          SubTimeLow: begin
            ent_o.op = OP_TIME_LOW;
            keep     = 1'b1;
          end
          SubTimeHigh: begin
            ent_o.op = OP_TIME_HIGH;
            keep     = 1'b1;
          end
          default: begin
            keep = 1'b0;
          end
        endcase
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && keep;

endmodule

@@ hw/rtl/ppt_queue.sv @@
// ----------------------------------------------------------------------------
// ppt_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ppt_queue import ppt_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t ent_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  qent_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign ent_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= ent_i;
    end
  end

endmodule

@@ hw/rtl/ppt_back.sv @@
// ----------------------------------------------------------------------------
// ppt_back
// Executes classified words: keeps the timestamp and trigger state, builds
// global times in stage one and final 64-bit times in the output stage.
// ----------------------------------------------------------------------------
module ppt_back import ppt_pkg::*; #(
  parameter int unsigned TRIG_WRAP_BITS = TrigWrapBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        ent_valid_i,
  input  qent_t       ent_i,
  output logic        ent_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  column_o,
  output logic [7:0]  row_index_o,
  output logic [14:0] tot_value_o,
  output logic [63:0] time_value_o,
  output logic [11:0] trigger_id_o,
  output logic [1:0]  warning_o
);

  localparam logic [8:0] FinePhase [16] = '{
    9'd298, 9'd0,   9'd42,  9'd85,  9'd128, 9'd170, 9'd213, 9'd256,
    9'd298, 9'd341, 9'd384, 9'd426, 9'd469, 9'd0,   9'd42,  9'd85
  };

  logic [47:0]               long_time_q, long_time_d;
  logic [31:0]               lt_low_q, lt_low_d;
  logic [31:0]               prev_coarse_q, prev_coarse_d;
  logic [TRIG_WRAP_BITS-1:0] wrap_cnt_q, wrap_cnt_d;
  logic                      first_seen_q, first_seen_d;
  logic [15:0]               margin_q;

  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_kind_q;
  logic [7:0]                s1_col_q;
  logic [7:0]                s1_row_q;
  logic [14:0]               s1_tot_q;
  logic [11:0]               s1_id_q;
  logic [1:0]                s1_warn_q;
  logic [47:0]               s1_g_q;
  logic signed [5:0]         s1_adj_q;
  logic [31:0]               s1_coarse_q;
  logic [11:0]               s1_fine_q;
  logic [TRIG_WRAP_BITS-1:0] s1_wrap_q;

  logic                      out_valid_q, out_valid_d;
  logic                      s1_ready;
  logic                      s2_ready;
  logic                      pop;
  logic                      produce;

  logic [63:0]               w;
  logic [1:0]                pbits;
  logic [1:0]                diff;
  logic [47:0]               base;
  logic [47:0]               g;
  logic                      pix_warn;

  logic [11:0]               trig_id;
  logic [31:0]               trig_coarse;
  logic [31:0]               thr;
  logic                      back_lt;
  logic                      wrapped;
  logic                      drop;
  logic [TRIG_WRAP_BITS-1:0] wrap_next;
  logic [1:0]                trig_warn;
  logic [11:0]               fine;

  logic [47:0]               cand;
  logic [48:0]               lt_plus;
  logic                      jump;
  logic [47:0]               hi_sub;

  logic [63:0]               pix_time;
  logic [75:0]               trig_ext;

  assign w = ent_i.word;

  // pixel: pull the kept long time to the packet's epoch
  assign pbits = w[15:14];
  assign diff  = long_time_q[29:28] - pbits;

  always_comb begin
    case (diff)
      2'd1:    base = long_time_q - QuarterEpoch;
      2'd3:    base = long_time_q + QuarterEpoch;
      default: base = long_time_q;
    endcase
  end

  assign g        = {base[47:30], w[15:0], w[43:30]};
  assign pix_warn = (g[29:28] != pbits);

  // trigger: wrap or small back jump
  assign trig_id     = w[55:44];
  assign trig_coarse = w[43:12];
  assign thr         = prev_coarse_q - {16'b0, margin_q};
  assign back_lt     = (trig_coarse < prev_coarse_q);
  assign wrapped     = back_lt && (trig_coarse < thr);
  assign drop        = !first_seen_q && (trig_id != 12'd1);
  assign wrap_next   = wrapped ? TRIG_WRAP_BITS'(wrap_cnt_q + 1'b1) : wrap_cnt_q;
  assign trig_warn   = wrapped ? WarnWrap : (back_lt ? WarnBackJump : WarnNone);
  assign fine        = {w[11:9], FinePhase[w[8:5]]};

  // timestamp high half
  assign cand    = {w[31:16], lt_low_q};
  assign lt_plus = {1'b0, long_time_q} + {1'b0, QuarterEpoch};
  assign jump    = ({1'b0, cand} > lt_plus) && (long_time_q != '0);
  assign hi_sub  = {w[31:16], 32'b0} - QuarterEpoch;

  assign s2_ready  = !out_valid_q || out_ready_i;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign pop       = ent_valid_i && s1_ready;
  assign ent_pop_o = pop;

  always_comb begin
    long_time_d   = long_time_q;
    lt_low_d      = lt_low_q;
    prev_coarse_d = prev_coarse_q;
    wrap_cnt_d    = wrap_cnt_q;
    first_seen_d  = first_seen_q;
    produce       = 1'b0;
    unique case (ent_i.op)
      OP_PIXEL: begin
        produce = 1'b1;
      end
      OP_TRIGGER: begin
        if (!drop) begin
          produce       = 1'b1;
          wrap_cnt_d    = wrap_next;
          prev_coarse_d = trig_coarse;
          first_seen_d  = 1'b1;
        end
      end
      OP_TIME_LOW: begin
        lt_low_d = w[47:16];
      end
      OP_TIME_HIGH: begin
        long_time_d = jump ? (hi_sub | {16'b0, lt_low_q}) : cand;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    s1_valid_d  = s1_ready ? (pop && produce) : s1_valid_q;
    out_valid_d = s2_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_time_q   <= '0;
      lt_low_q      <= '0;
      prev_coarse_q <= '0;
      wrap_cnt_q    <= '0;
      first_seen_q  <= 1'b0;
      margin_q      <= MarginReset;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop) begin
        long_time_q   <= long_time_d;
        lt_low_q      <= lt_low_d;
        prev_coarse_q <= prev_coarse_d;
        wrap_cnt_q    <= wrap_cnt_d;
        first_seen_q  <= first_seen_d;
      end
      if (cfg_we_i) begin
        margin_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_g_q      <= g;
      s1_adj_q    <= ent_i.adj;
      s1_coarse_q <= trig_coarse;
      s1_fine_q   <= fine;
      s1_wrap_q   <= wrap_next;
      if (ent_i.op == OP_PIXEL) begin
        s1_kind_q <= KindPixel;
        s1_col_q  <= ent_i.column;
        s1_row_q  <= ent_i.row_index;
        s1_tot_q  <= ent_i.tot_value;
        s1_id_q   <= '0;
        s1_warn_q <= pix_warn ? WarnEpoch : WarnNone;
      end else begin
        s1_kind_q <= KindTrigger;
        s1_col_q  <= '0;
        s1_row_q  <= '0;
        s1_tot_q  <= '0;
        s1_id_q   <= trig_id;
        s1_warn_q <= trig_warn;
      end
    end
  end

  assign pix_time = {4'b0, s1_g_q, 12'b0} + {{50{s1_adj_q[5]}}, s1_adj_q, 8'b0};
  assign trig_ext = {32'(s1_wrap_q), s1_coarse_q, s1_fine_q};

  // output register
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      kind_o       <= s1_kind_q;
      column_o     <= s1_col_q;
      row_index_o  <= s1_row_q;
      tot_value_o  <= s1_tot_q;
      trigger_id_o <= s1_id_q;
      warning_o    <= s1_warn_q;
      time_value_o <= (s1_kind_q == KindPixel) ? pix_time : trig_ext[63:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pixel_packet_time_decoder.sv @@
// ----------------------------------------------------------------------------
// pixel_packet_time_decoder
// Decodes 64-bit detector packets into pixel hits and trigger records with
// extended 64-bit times.
// ----------------------------------------------------------------------------
// Channel  Payload                                    Handshake
// input    packet_word_i                              in_valid_i / in_ready_o
// output   kind_o column_o row_index_o tot_value_o    out_valid_o / out_ready_i
//          time_value_o trigger_id_o warning_o
// config   cfg_data_i (backjump margin)               cfg_we_i, no wait
//
// One word per cycle sustained while the output does not stall; a hit or
// trigger turns valid on the output once it has passed the queue write, the
// state stage and the output register with the time adder in front of it.
// Timestamp words and early triggers with an id other than one leave no result.
// Reset clears all time state and sets the margin to 1000.
// An output stall backs up the two stages and then the QUEUE_DEPTH-word queue.
// ----------------------------------------------------------------------------
module pixel_packet_time_decoder import ppt_pkg::*; #(
  parameter int unsigned TRIG_WRAP_BITS = TrigWrapBitsDefault,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] packet_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  column_o,
  output logic [7:0]  row_index_o,
  output logic [14:0] tot_value_o,
  output logic [63:0] time_value_o,
  output logic [11:0] trigger_id_o,
  output logic [1:0]  warning_o
);

  logic  queue_full;
  logic  push;
  qent_t front_ent;
  logic  queue_valid;
  qent_t queue_ent;
  logic  pop;

  ppt_front u_front (
    .in_valid_i    (in_valid_i),
    .packet_word_i (packet_word_i),
    .in_ready_o    (in_ready_o),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .ent_o         (front_ent)
  );

  ppt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (front_ent),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .ent_o   (queue_ent)
  );

  ppt_back #(
    .TRIG_WRAP_BITS (TRIG_WRAP_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .ent_valid_i  (queue_valid),
    .ent_i        (queue_ent),
    .ent_pop_o    (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .column_o     (column_o),
    .row_index_o  (row_index_o),
    .tot_value_o  (tot_value_o),
    .time_value_o (time_value_o),
    .trigger_id_o (trigger_id_o),
    .warning_o    (warning_o)
  );

endmodule

@@ bench/packet_record_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_record_checker
// Watches the packet and record channels of the time decoder, decodes every
// accepted packet word into the hit or trigger record it should produce, and
// compares each accepted record field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module packet_record_checker import ppt_pkg::*; #(
  parameter int unsigned TRIG_WRAP_BITS = TrigWrapBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] packet_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_index_i,
  input  logic [14:0] tot_value_i,
  input  logic [63:0] time_value_i,
  input  logic [11:0] trigger_id_i,
  input  logic [1:0]  warning_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  column;
    logic [7:0]  row_index;
    logic [14:0] tot_value;
    logic [63:0] time_value;
    logic [11:0] trigger_id;
    logic [1:0]  warning;
  } record_t;

  localparam int ExpDepth = 256;

  record_t                   expected_mem[ExpDepth];
  int                        exp_head;
  int                        exp_tail;
  logic [47:0]               long_time;
  logic [31:0]               long_time_low;
  logic [31:0]               prev_coarse;
  logic [TRIG_WRAP_BITS-1:0] wrap_count;
  logic                      first_trigger_seen;
  logic [15:0]               margin;
  int                        mismatches;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40) begin
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic store_record(input record_t rec);
    expected_mem[exp_tail % ExpDepth] = rec;
    exp_tail++;
  endtask

  task automatic decode_packet(input logic [63:0] w);
    record_t     rec;
    logic [7:0]  col;
    logic [29:0] coarse30;
    logic [1:0]  pbits;
    logic [1:0]  diff;
    logic [3:0]  ph;
    logic [63:0] base;
    logic [63:0] g64;
    logic [63:0] t;
    logic [63:0] phase_q;
    logic [63:0] fine;
    logic [63:0] high;
    logic [63:0] cand;
    logic [31:0] coarse32;
    logic [31:0] floor32;
    logic [11:0] id;
    logic [1:0]  warn;
    rec = '0;
    if (w[63:60] == HdrPixelA || w[63:60] == HdrPixelB) begin
      col = {w[59:53], 1'b0} + {7'd0, w[46]};
      coarse30 = {w[15:0], w[43:30]};
      pbits = coarse30[29:28];
      diff = long_time[29:28] - pbits;
      base = {16'd0, long_time};
      if (diff == 2'd1) begin
        base = base - {16'd0, QuarterEpoch};
      end else if (diff == 2'd3) begin
        base = base + {16'd0, QuarterEpoch};
      end
      g64 = {16'd0, base[47:30], coarse30};
      t = (g64 << 12) - ({60'd0, w[19:16]} << 8);
      ph = col[4:1];
      t = t + ({60'd0, ph} << 8);
      if (ph == 4'd0) begin
        t = t + (64'd16 << 8);
      end
      rec.kind = KindPixel;
      rec.column = col;
      rec.row_index = {w[52:47], 2'b00} + {6'd0, w[45:44]};
      rec.tot_value = 15'(w[29:20]) * TotScale;
      rec.time_value = t;
      rec.warning = (g64[29:28] != pbits) ? WarnEpoch : WarnNone;
      store_record(rec);
    end else if (w[63:60] == HdrGlobalA || w[63:60] == HdrGlobalB) begin
      if (w[59:56] == SubTrigger) begin
        id = w[55:44];
        if (first_trigger_seen || id == 12'd1) begin
          coarse32 = w[43:12];
          phase_q = ({60'd0, w[8:5]} - 64'd1) << 9;
          phase_q = phase_q / 64'd12;
          fine = {52'd0, w[11:9], phase_q[8:0]};
          warn = WarnNone;
          floor32 = prev_coarse - {16'd0, margin};
          if (coarse32 < prev_coarse) begin
            if (coarse32 < floor32) begin
              wrap_count = wrap_count + 1'b1;
              warn = WarnWrap;
            end else begin
              warn = WarnBackJump;
            end
          end
          first_trigger_seen = 1'b1;
          prev_coarse = coarse32;
          t = (((64'(wrap_count) << 32) + {32'd0, coarse32}) << 12) | fine;
          rec.kind = KindTrigger;
          rec.time_value = t;
          rec.trigger_id = id;
          rec.warning = warn;
          store_record(rec);
        end
      end else if (w[59:56] == SubTimeLow) begin
        long_time_low = w[47:16];
      end else if (w[59:56] == SubTimeHigh) begin
        high = {16'd0, w[31:16], 32'd0};
        cand = high | {32'd0, long_time_low};
        if (cand > {16'd0, long_time} + {16'd0, QuarterEpoch} && long_time != 48'd0) begin
          t = (high - {16'd0, QuarterEpoch}) | {32'd0, long_time_low};
          long_time = t[47:0];
        end else begin
          long_time = cand[47:0];
        end
      end
    end
  endtask

  task automatic check_record();
    record_t want;
    if (exp_tail == exp_head) begin
      report_mismatch("record with none pending, time", time_value_i, 64'd0);
      return;
    end
    want = expected_mem[exp_head % ExpDepth];
    exp_head++;
    if (kind_i != want.kind) report_mismatch("kind", 64'(kind_i), 64'(want.kind));
    if (column_i != want.column) report_mismatch("column", 64'(column_i), 64'(want.column));
    if (row_index_i != want.row_index) begin
      report_mismatch("row_index", 64'(row_index_i), 64'(want.row_index));
    end
    if (tot_value_i != want.tot_value) begin
      report_mismatch("tot_value", 64'(tot_value_i), 64'(want.tot_value));
    end
    if (time_value_i != want.time_value) begin
      report_mismatch("time_value", time_value_i, want.time_value);
    end
    if (trigger_id_i != want.trigger_id) begin
      report_mismatch("trigger_id", 64'(trigger_id_i), 64'(want.trigger_id));
    end
    if (warning_i != want.warning) begin
      report_mismatch("warning", 64'(warning_i), 64'(want.warning));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_time = '0;
      long_time_low = '0;
      prev_coarse = '0;
      wrap_count = '0;
      first_trigger_seen = 1'b0;
      margin = MarginReset;
      mismatches = 0;
      exp_head = 0;
      exp_tail = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_record();
      if (cfg_we_i) margin = cfg_data_i;
      if (in_valid_i && in_ready_i) decode_packet(packet_word_i);
      mismatch_count_o <= mismatches;
      pending_count_o <= exp_tail - exp_head;
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the pixel packet time decoder with directed and random packet words
// (pixel hits, triggers, timestamp pairs, broken pairs and junk) under random
// idling on both channels and several backjump margins; the record checker
// beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module testbench;
  import ppt_pkg::*;

  localparam int unsigned WrapBits      = TrigWrapBitsDefault;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned ItemsPerPhase = 210;
  localparam int unsigned HoldCycles    = 160;
  localparam int unsigned HoldAfter     = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] packet_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  column_o;
  logic [7:0]  row_index_o;
  logic [14:0] tot_value_o;
  logic [63:0] time_value_o;
  logic [11:0] trigger_id_o;
  logic [1:0]  warning_o;

  int          mismatch_count;
  int          pending_count;
  int unsigned words_taken = 0;
  int unsigned quiet_cycles = 0;
  logic        tx_burst = 1'b0;
  logic        rx_burst = 1'b0;
  logic        hold_done = 1'b0;
  logic [31:0] trig_coarse = 32'd100;
  logic [11:0] trig_id = 12'd1;
  logic [47:0] stamp_time = '0;
  logic [15:0] margin_now = MarginReset;

  always #2 clk_i = ~clk_i;

  pixel_packet_time_decoder #(
    .TRIG_WRAP_BITS(WrapBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .packet_word_i(packet_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .column_o     (column_o),
    .row_index_o  (row_index_o),
    .tot_value_o  (tot_value_o),
    .time_value_o (time_value_o),
    .trigger_id_o (trigger_id_o),
    .warning_o    (warning_o)
  );

  packet_record_checker #(
    .TRIG_WRAP_BITS(WrapBits)
  ) records_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .packet_word_i   (packet_word_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_i          (kind_o),
    .column_i        (column_o),
    .row_index_i     (row_index_o),
    .tot_value_i     (tot_value_o),
    .time_value_i    (time_value_o),
    .trigger_id_i    (trigger_id_o),
    .warning_i       (warning_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  function automatic int unsigned pick_idle(input logic burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [3:0] global_hdr();
    return ($urandom_range(0, 1) != 0) ? HdrGlobalB : HdrGlobalA;
  endfunction

  task automatic send_word(input logic [63:0] w);
    int unsigned gap;
    gap = pick_idle(tx_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    packet_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_taken++;
  endtask

  task automatic send_time_low(input logic [31:0] low);
    send_word({global_hdr(), SubTimeLow, 8'($urandom), low, 16'($urandom)});
  endtask

  task automatic send_time_high(input logic [15:0] high);
    send_word({global_hdr(), SubTimeHigh, 24'($urandom), high, 16'($urandom)});
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_margin(input logic [15:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    margin_now = value;
  endtask

  task automatic send_directed();
    logic [63:0] script[$];
    script = '{
      {HdrGlobalA, SubTrigger, 12'd7, 32'd500, 12'h000},
      {HdrGlobalB, SubTrigger, 12'd1, 32'd100, 12'h000},
      {HdrPixelB, 60'hFFF_FFFF_FFFF_FFFF},
      {HdrPixelA, 60'h000_0000_0000_0000},
      {HdrGlobalA, SubTimeLow, 8'hFF, 32'h3000_0000, 16'hFFFF},
      {HdrGlobalB, SubTimeHigh, 24'h00_0000, 16'h0000, 16'h0000},
      {HdrGlobalA, SubTimeHigh, 24'hFF_FFFF, 16'h0001, 16'hFFFF},
      {HdrPixelA, 44'h123_4567_89AB, 16'h8000},
      {HdrPixelB, 44'hFED_CBA9_8765, 16'h0123},
      {HdrPixelA, 44'h0F0_F0F0_F0F0, 16'hC001},
      {HdrPixelB, 44'h555_5555_5555, 16'h4AAA},
      {HdrGlobalA, SubTrigger, 12'd2, 32'd50, 12'hFFF},
      {HdrGlobalB, SubTrigger, 12'd3, 32'd2000, 12'h020},
      {HdrGlobalA, SubTrigger, 12'd4, 32'd10, 12'h1E0},
      {HdrGlobalB, SubTrigger, 12'hFFF, 32'hFFFF_FFFF, 12'h000},
      {HdrGlobalA, SubTrigger, 12'h000, 32'h0000_0000, 12'hE00},
      {4'h7, 60'hABC_DEF0_1234_5678},
      {HdrGlobalA, 4'h0, 56'h12_3456_789A_BCDE},
      {4'hF, 60'hFFF_FFFF_FFFF_FFFF},
      {HdrGlobalB, 4'hE, 56'hFF_FFFF_FFFF_FFFF},
      {HdrGlobalB, SubTimeLow, 8'h00, 32'hFFFF_FFFF, 16'h0000},
      {HdrGlobalA, SubTimeHigh, 24'h00_0000, 16'h0000, 16'h0000},
      {HdrGlobalA, SubTimeLow, 8'h00, 32'hA000_0000, 16'h0000},
      {HdrGlobalB, SubTimeHigh, 24'h00_0000, 16'h0000, 16'h0000},
      {HdrPixelA, 44'hA5A_5A5A_5A5A, 16'h5A5A}
    };
    foreach (script[i]) send_word(script[i]);
    trig_coarse = 32'd0;
    trig_id = 12'd0;
  endtask

  task automatic send_trigger();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      trig_coarse = trig_coarse + $urandom_range(0, 5000);
    end else if (r < 78) begin
      trig_coarse = trig_coarse;
    end else if (r < 90) begin
      trig_coarse = trig_coarse - $urandom_range(0, 32'(margin_now) + 16);
    end else if (r < 97) begin
      trig_coarse = $urandom_range(0, 4096);
    end else begin
      trig_coarse = $urandom;
    end
    trig_id = trig_id + 12'd1;
    send_word({global_hdr(), SubTrigger, trig_id, trig_coarse, 12'($urandom)});
  endtask

  task automatic send_pixel();
    logic [59:0] body;
    logic [29:0] near;
    body = 60'({$urandom, $urandom});
    if ($urandom_range(0, 1) != 0) begin
      near = stamp_time[29:0] + 30'($urandom_range(0, 32'h1FFF_FFFF)) - 30'h1000_0000;
      body[15:0] = near[29:14];
      body[43:30] = near[13:0];
    end
    send_word({($urandom_range(0, 1) != 0) ? HdrPixelB : HdrPixelA, body});
  endtask

  task automatic send_junk();
    logic [63:0] w;
    logic [3:0]  hdr;
    logic [3:0]  sub;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 1) != 0) begin
      hdr = 4'($urandom_range(0, 15));
      while (hdr == HdrPixelA || hdr == HdrPixelB || hdr == HdrGlobalA || hdr == HdrGlobalB) begin
        hdr = 4'($urandom_range(0, 15));
      end
      w[63:60] = hdr;
    end else begin
      sub = 4'($urandom_range(0, 15));
      while (sub == SubTrigger || sub == SubTimeLow || sub == SubTimeHigh) begin
        sub = 4'($urandom_range(0, 15));
      end
      w[63:56] = {global_hdr(), sub};
    end
    send_word(w);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done_items;
    int unsigned r;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(0, 39) == 0) tx_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 42) begin
        send_pixel();
        done_items++;
      end else if (r < 72) begin
        send_trigger();
        done_items++;
      end else if (r < 86) begin
        r = $urandom_range(0, 19);
        if (r < 15) begin
          stamp_time = stamp_time + 48'($urandom_range(0, 32'h0800_0000));
        end else if (r < 19) begin
          stamp_time = stamp_time + {16'd0, $urandom};
        end else begin
          stamp_time = 48'({$urandom, $urandom});
        end
        send_time_low(stamp_time[31:0]);
        send_time_high(stamp_time[47:32]);
        done_items += 2;
      end else if (r < 90) begin
        if ($urandom_range(0, 1) != 0) send_time_low($urandom);
        else send_time_high(16'($urandom));
        done_items++;
      end else begin
        send_junk();
        done_items++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, bursts, and one long hold-off to back up the queue.
  initial begin
    int unsigned stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!hold_done && words_taken >= HoldAfter) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) rx_burst = ($urandom_range(0, 2) == 0);
        stall = pick_idle(rx_burst);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    run_random(ItemsPerPhase);
    set_margin(16'd0);
    run_random(ItemsPerPhase);
    set_margin(16'hFFFF);
    run_random(ItemsPerPhase);
    set_margin(16'($urandom_range(1, 16'hFFFE)));
    run_random(ItemsPerPhase);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
